FILE: design/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg
// Shared widths, register indexes and queue types for the camera ray block.
// ----------------------------------------------------------------------------
package crd_pkg;

   localparam int PIX_W      = 10;
   localparam int WIN_WIDTH  = 1024;   // power of two
   localparam int WIN_HEIGHT = 1024;   // power of two
   localparam int W_SHIFT    = $clog2(WIN_WIDTH);
   localparam int H_SHIFT    = $clog2(WIN_HEIGHT);
   localparam int MIN_SHIFT  = (W_SHIFT < H_SHIFT) ? W_SHIFT : H_SHIFT;

   localparam int AXIS_W  = 48;
   localparam int COMP_W  = 16;
   localparam int SCALE_W = 24;
   localparam int CSR_W   = 48;
   localparam int CSR_IDX_W = 3;

   localparam int NX_W   = PIX_W + 4;
   localparam int PROD_W = NX_W + SCALE_W + 1;
   localparam int UV_W   = PROD_W - MIN_SHIFT + 1;

   localparam int TERM_W = COMP_W + UV_W;
   localparam int S_W    = TERM_W + 2;
   localparam int K_W    = $clog2(S_W + 1);
   localparam int NORM_W = 30;
   localparam int SQR_W  = 2 * NORM_W;
   localparam int SQ_W   = SQR_W + 2;
   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int ROOT_W = SQRT_STEPS;
   localparam int FRAC_W = 14;
   localparam int QUO_W  = FRAC_W + 1;
   localparam int NUM_W  = NORM_W + FRAC_W + 1;
   localparam int DEN_W  = ROOT_W + QUO_W;
   localparam int DIR_W  = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   localparam logic [CSR_IDX_W-1:0] REG_FORWARD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_UP      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HSCALE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VSCALE  = 3'd4;

   typedef struct packed {
      logic signed [UV_W-1:0] u;
      logic signed [UV_W-1:0] v;
   } uv_type;

endpackage

FILE: design/crd_front.sv
// ----------------------------------------------------------------------------
// crd_front
// Accept pixels and compute the rounded screen offsets u and v.
// ----------------------------------------------------------------------------
module crd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [crd_pkg::PIX_W-1:0]    req_pixel_x,
   input  logic [crd_pkg::PIX_W-1:0]    req_pixel_y,
   input  logic [crd_pkg::SCALE_W-1:0]  hscale,
   input  logic [crd_pkg::SCALE_W-1:0]  vscale,
   output logic                         push,
   input  logic                         full,
   output crd_pkg::uv_type              push_item
);
   import crd_pkg::*;

   logic                     valid_ff, valid_in;
   uv_type                   item_ff, item_in;
   logic                     advance;
   logic signed [NX_W-1:0]   nx, ny;
   logic signed [PROD_W-1:0] prod_u, prod_v;

   function automatic logic signed [UV_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] p, input int sh);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] q;
      logic [UV_W-1:0]   qt;
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      q   = (mag + (PROD_W'(1) << (sh - 1))) >> sh;
      qt  = q[UV_W-1:0];
      return p[PROD_W-1] ? $signed(-qt) : $signed(qt);
   endfunction

   assign nx = $signed({{(NX_W-PIX_W-1){1'b0}}, req_pixel_x, 1'b1})
               - $signed(NX_W'(WIN_WIDTH));
   assign ny = $signed(NX_W'(WIN_HEIGHT))
               - $signed({{(NX_W-PIX_W-1){1'b0}}, req_pixel_y, 1'b1});
   assign prod_u = nx * $signed({1'b0, hscale});
   assign prod_v = ny * $signed({1'b0, vscale});

   assign push      = valid_ff && !full;
   assign push_item = item_ff;
   assign advance   = !valid_ff || !full;
   assign req_stall = !advance;

   always_comb begin
      valid_in  = valid_ff;
      item_in   = item_ff;
      if (advance) begin
         valid_in  = req_valid;
         item_in.u = round_shift(prod_u, W_SHIFT);
         item_in.v = round_shift(prod_v, H_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

FILE: design/crd_queue.sv
// ----------------------------------------------------------------------------
// crd_queue
// Short queue of screen offsets between front and back.
// ----------------------------------------------------------------------------
module crd_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  crd_pkg::uv_type push_item,
   output logic            full,
   input  logic            pop,
   output logic            empty,
   output crd_pkg::uv_type head
);
   import crd_pkg::*;

   uv_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: design/crd_back.sv
// ----------------------------------------------------------------------------
// crd_back
// Sum the camera axes, normalize, take the square root and divide.
// ----------------------------------------------------------------------------
module crd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              empty,
   input  crd_pkg::uv_type                   head,
   output logic                              pop,
   input  logic [crd_pkg::AXIS_W-1:0]        forward_axis,
   input  logic [crd_pkg::AXIS_W-1:0]        right_axis,
   input  logic [crd_pkg::AXIS_W-1:0]        up_axis,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [crd_pkg::DIR_W-1:0]  rsp_dir_x,
   output logic signed [crd_pkg::DIR_W-1:0]  rsp_dir_y,
   output logic signed [crd_pkg::DIR_W-1:0]  rsp_dir_z,
   output logic                              rsp_zero_length
);
   import crd_pkg::*;

   typedef struct packed {
      logic [2:0][NORM_W-1:0] n;
      logic [2:0]             neg;
      logic                   zero;
   } side_type;

   logic advance;

   logic                           v1_ff;
   logic signed [2:0][TERM_W-1:0]  pr_ff, pv_ff;
   logic signed [2:0][COMP_W-1:0]  f_ff;

   logic                           v2_ff;
   logic signed [2:0][S_W-1:0]     s_ff;

   logic                           v3_ff;
   logic [2:0][S_W-1:0]            m3_ff;
   logic [2:0]                     neg3_ff;
   logic [S_W-1:0]                 or3;

   logic                           v4_ff;
   logic [2:0][S_W-1:0]            m4_ff;
   logic [2:0]                     neg4_ff;
   logic [K_W-1:0]                 k4_ff, k_in;
   logic                           zero4_ff;

   logic                           v5_ff;
   side_type                       side5_ff;
   logic [2:0][NORM_W-1:0]         n5_in;

   logic                           v6_ff;
   side_type                       side6_ff;
   logic [2:0][SQR_W-1:0]          sq6_ff;

   logic                           sv_ff   [SQRT_STEPS+1];
   side_type                       sside_ff[SQRT_STEPS+1];
   logic [SQ_W-1:0]                srem_ff [SQRT_STEPS+1];
   logic [SQ_W-1:0]                sres_ff [SQRT_STEPS+1];

   logic                           dv_ff   [QUO_W+1];
   side_type                       dside_ff[QUO_W+1];
   logic [ROOT_W-1:0]              dl_ff   [QUO_W+1];
   logic [2:0][NUM_W-1:0]          drem_ff [QUO_W+1];
   logic [2:0][QUO_W-1:0]          dq_ff   [QUO_W+1];

   logic                           out_valid_ff;
   logic signed [2:0][DIR_W-1:0]   dir_ff;
   logic                           zero_ff;

   assign advance = !(out_valid_ff && rsp_stall);
   assign pop     = advance && !empty;

   // products
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= !empty;
      end
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            f_ff[i]  <= $signed(forward_axis[COMP_W*i +: COMP_W]);
            pr_ff[i] <= $signed(right_axis[COMP_W*i +: COMP_W]) * head.u;
            pv_ff[i] <= $signed(up_axis[COMP_W*i +: COMP_W]) * head.v;
         end
      end
   end

   // sums
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            s_ff[i] <= (S_W'($signed(f_ff[i])) <<< 16) + S_W'($signed(pr_ff[i]))
                       + S_W'($signed(pv_ff[i]));
         end
      end
   end

   // magnitudes
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            neg3_ff[i] <= s_ff[i][S_W-1];
            m3_ff[i]   <= s_ff[i][S_W-1] ? S_W'(-s_ff[i]) : S_W'(s_ff[i]);
         end
      end
   end

   // bit length of the largest magnitude
   assign or3 = m3_ff[0] | m3_ff[1] | m3_ff[2];
   always_comb begin
      k_in = '0;
      for (int b = 0; b < S_W; b++) begin
         if (or3[b]) begin
            k_in = K_W'(b + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
      if (advance) begin
         m4_ff    <= m3_ff;
         neg4_ff  <= neg3_ff;
         k4_ff    <= k_in;
         zero4_ff <= (or3 == '0);
      end
   end

   // normalize
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (k4_ff > K_W'(NORM_W)) begin
            n5_in[i] = NORM_W'(m4_ff[i] >> (k4_ff - K_W'(NORM_W)));
         end else begin
            n5_in[i] = NORM_W'(m4_ff[i] << (K_W'(NORM_W) - k4_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v4_ff;
      end
      if (advance) begin
         side5_ff.n    <= n5_in;
         side5_ff.neg  <= neg4_ff;
         side5_ff.zero <= zero4_ff;
      end
   end

   // squares
   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (advance) begin
         v6_ff <= v5_ff;
      end
      if (advance) begin
         side6_ff <= side5_ff;
         for (int i = 0; i < 3; i++) begin
            sq6_ff[i] <= side5_ff.n[i] * side5_ff.n[i];
         end
      end
   end

   // sum of squares
   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (advance) begin
         sv_ff[0] <= v6_ff;
      end
      if (advance) begin
         sside_ff[0] <= side6_ff;
         srem_ff[0]  <= SQ_W'(sq6_ff[0]) + SQ_W'(sq6_ff[1]) + SQ_W'(sq6_ff[2]);
         sres_ff[0]  <= '0;
      end
   end

   // square root, one result bit per stage
   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - g));
      logic [SQ_W-1:0] trial;
      assign trial = sres_ff[g] + BIT;
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[g+1] <= 1'b0;
         end else if (advance) begin
            sv_ff[g+1] <= sv_ff[g];
         end
         if (advance) begin
            sside_ff[g+1] <= sside_ff[g];
            if (srem_ff[g] >= trial) begin
               srem_ff[g+1] <= srem_ff[g] - trial;
               sres_ff[g+1] <= (sres_ff[g] >> 1) + BIT;
            end else begin
               srem_ff[g+1] <= srem_ff[g];
               sres_ff[g+1] <= sres_ff[g] >> 1;
            end
         end
      end
   end

   // load the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (advance) begin
         dv_ff[0] <= sv_ff[SQRT_STEPS];
      end
      if (advance) begin
         dside_ff[0] <= sside_ff[SQRT_STEPS];
         dl_ff[0]    <= sres_ff[SQRT_STEPS][ROOT_W-1:0];
         dq_ff[0]    <= '0;
         for (int i = 0; i < 3; i++) begin
            drem_ff[0][i] <= (NUM_W'(sside_ff[SQRT_STEPS].n[i]) << FRAC_W)
                             + NUM_W'(sres_ff[SQRT_STEPS][ROOT_W-1:1]);
         end
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      localparam int SH = QUO_W - 1 - g;
      logic [DEN_W-1:0] den;
      assign den = DEN_W'(dl_ff[g]) << SH;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[g+1] <= 1'b0;
         end else if (advance) begin
            dv_ff[g+1] <= dv_ff[g];
         end
         if (advance) begin
            dside_ff[g+1] <= dside_ff[g];
            dl_ff[g+1]    <= dl_ff[g];
            for (int i = 0; i < 3; i++) begin
               if (DEN_W'(drem_ff[g][i]) >= den) begin
                  drem_ff[g+1][i]   <= NUM_W'(DEN_W'(drem_ff[g][i]) - den);
                  dq_ff[g+1][i]     <= dq_ff[g][i] | (QUO_W'(1) << SH);
               end else begin
                  drem_ff[g+1][i]   <= drem_ff[g][i];
                  dq_ff[g+1][i]     <= dq_ff[g][i];
               end
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_ff[QUO_W];
      end
      if (advance) begin
         zero_ff <= dside_ff[QUO_W].zero;
         for (int i = 0; i < 3; i++) begin
            if (dside_ff[QUO_W].zero) begin
               dir_ff[i] <= '0;
            end else if (dside_ff[QUO_W].neg[i]) begin
               dir_ff[i] <= -$signed(DIR_W'(dq_ff[QUO_W][i]));
            end else begin
               dir_ff[i] <= $signed(DIR_W'(dq_ff[QUO_W][i]));
            end
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_dir_x       = dir_ff[0];
   assign rsp_dir_y       = dir_ff[1];
   assign rsp_dir_z       = dir_ff[2];
   assign rsp_zero_length = zero_ff;

endmodule

FILE: design/camera_ray_direction.sv
// ----------------------------------------------------------------------------
// camera_ray_direction
// Pinhole camera primary ray generator: unit ray direction per pixel.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_pixel_x, req_pixel_y
//   rsp      out        rsp_valid/rsp_stall   rsp_dir_x/y/z, rsp_zero_length
//   csr      in         csr_write             csr_index, csr_data
//
// One pixel per cycle sustained while rsp is not stalled; the back end holds the
// one-bit-per-stage square root and divider pipelines.
// A four-entry queue separates the offset stage from the back pipeline.
// Reset is synchronous; registers return to the identity camera.
// A stall on rsp freezes the back pipeline; req stalls once the queue fills.
// ----------------------------------------------------------------------------
module camera_ray_direction (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [crd_pkg::PIX_W-1:0]           req_pixel_x,
   input  logic [crd_pkg::PIX_W-1:0]           req_pixel_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [crd_pkg::DIR_W-1:0]    rsp_dir_x,
   output logic signed [crd_pkg::DIR_W-1:0]    rsp_dir_y,
   output logic signed [crd_pkg::DIR_W-1:0]    rsp_dir_z,
   output logic                                rsp_zero_length,
   input  logic                                csr_write,
   input  logic [crd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [crd_pkg::CSR_W-1:0]           csr_data
);
   import crd_pkg::*;

   logic [AXIS_W-1:0]  forward_ff, right_ff, up_ff;
   logic [SCALE_W-1:0] hscale_ff, vscale_ff;

   logic   push, full, pop, empty;
   uv_type push_item, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         forward_ff <= 48'h4000_0000_0000;
         right_ff   <= 48'h0000_0000_4000;
         up_ff      <= 48'h0000_4000_0000;
         hscale_ff  <= 24'h01_0000;
         vscale_ff  <= 24'h01_0000;
      end else if (csr_write) begin
         case (csr_index)
            REG_FORWARD: forward_ff <= csr_data[AXIS_W-1:0];
            REG_RIGHT:   right_ff   <= csr_data[AXIS_W-1:0];
            REG_UP:      up_ff      <= csr_data[AXIS_W-1:0];
            REG_HSCALE:  hscale_ff  <= csr_data[SCALE_W-1:0];
            REG_VSCALE:  vscale_ff  <= csr_data[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   crd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .hscale      (hscale_ff),
      .vscale      (vscale_ff),
      .push        (push),
      .full        (full),
      .push_item   (push_item)
   );

   crd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   crd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (empty),
      .head            (head),
      .pop             (pop),
      .forward_axis    (forward_ff),
      .right_axis      (right_ff),
      .up_axis         (up_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dir_x       (rsp_dir_x),
      .rsp_dir_y       (rsp_dir_y),
      .rsp_dir_z       (rsp_dir_z),
      .rsp_zero_length (rsp_zero_length)
   );

endmodule
